// File: rtl/core/mobt_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and fixed-point helpers for the online backprop trainer.
// Used by every module under rtl/core except mobt_chk; depends on nothing.
package mobt_pkg;

   localparam int WINDOW    = 6;
   localparam int HIDDEN    = 2;
   localparam int FRAC_BITS = 24;

   localparam int NW   = HIDDEN * WINDOW;
   localparam int NALL = NW + 2 * HIDDEN + 1;

   localparam int DW    = 32;
   localparam int ACC_W = 48;
   localparam int NUM_W = FRAC_BITS + 34;
   localparam int DCW   = $clog2(NUM_W + 1);
   localparam int PW    = (NW > 1) ? $clog2(NW) : 1;
   localparam int KW    = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
   localparam int IW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CW    = $clog2(WINDOW + 1);
   localparam int XW    = 5;
   localparam int RW    = 31;

   localparam logic [2:0] REQ_TRAIN   = 3'd0;
   localparam logic [2:0] REQ_PREDICT = 3'd1;
   localparam logic [2:0] REQ_WRITE   = 3'd2;
   localparam logic [2:0] REQ_READ    = 3'd3;
   localparam logic [2:0] REQ_CLEAR   = 3'd4;

   localparam logic [RW-1:0] RATE_RESET = 31'd11744051;

   localparam logic signed [DW-1:0] ONE    = DW'(64'd1 << FRAC_BITS);
   localparam logic signed [DW-1:0] POLY_A = 32'sd721095906;
   localparam logic signed [DW-1:0] POLY_B = 32'sd184224994;
   localparam logic signed [DW-1:0] S32_MAX = 32'sh7FFF_FFFF;

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sd2147483648);

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DW-1:0]    den;
   } div_cmd_type;

   function automatic logic signed [ACC_W-1:0] sext(input logic signed [DW-1:0] x);
      return {{(ACC_W - DW){x[DW-1]}}, x};
   endfunction

   function automatic logic signed [DW-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [DW-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[DW-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[DW-1:0];
      end else begin
         r = v[DW-1:0];
      end
      return r;
   endfunction

   // floor(p / 2^FRAC_BITS); fits easily since |p| <= 2^62
   function automatic logic signed [ACC_W-1:0] shr_frac(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p >>> FRAC_BITS;
      return s[ACC_W-1:0];
   endfunction

   function automatic logic signed [DW-1:0] qmul(input logic signed [63:0] p);
      return sat32(shr_frac(p));
   endfunction

endpackage

// File: rtl/core/mobt_mul.sv
`timescale 1ns / 1ps
// Shared 32x32 signed multiplier with a registered product.
// Depends on mobt_pkg for widths.
module mobt_mul (
   input  logic                          clock,
   input  logic signed [mobt_pkg::DW-1:0] op_a,
   input  logic signed [mobt_pkg::DW-1:0] op_b,
   output logic signed [63:0]            prod
);

   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;

   assign prod_in = op_a * op_b;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// File: rtl/core/mobt_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle, NUM_W-bit quotient.
// Depends on mobt_pkg for widths and the command struct.
module mobt_div (
   input  logic                          clock,
   input  logic                          reset,
   input  mobt_pkg::div_cmd_type         cmd,
   output logic                          done,
   output logic [mobt_pkg::NUM_W-1:0]    quot
);

   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [mobt_pkg::DCW-1:0]      cnt_ff, cnt_in;
   logic [mobt_pkg::DW-1:0]       rem_ff, rem_in;
   logic [mobt_pkg::DW-1:0]       den_ff, den_in;
   logic [mobt_pkg::NUM_W-1:0]    quo_ff, quo_in;
   logic [mobt_pkg::DW:0]         rem_sh;
   logic [mobt_pkg::DW+1:0]       diff;

   assign done = done_ff;
   assign quot = quo_ff;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[mobt_pkg::NUM_W-1]};
      diff    = {1'b0, rem_sh} - {2'b00, den_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (cmd.start) begin
         run_in = 1'b1;
         cnt_in = mobt_pkg::DCW'(mobt_pkg::NUM_W);
         rem_in = '0;
         den_in = cmd.den;
         quo_in = cmd.num;
      end else if (run_ff) begin
         // shift in the next numerator bit, subtract when it fits
         if (!diff[mobt_pkg::DW+1]) begin
            rem_in = diff[mobt_pkg::DW-1:0];
            quo_in = {quo_ff[mobt_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[mobt_pkg::DW-1:0];
            quo_in = {quo_ff[mobt_pkg::NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == mobt_pkg::DCW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

endmodule

// File: rtl/core/mlp_online_backprop_trainer.sv
`timescale 1ns / 1ps
// Each multiply on the shared multiplier has an issue and a write-back phase; the sigmoid
// divisions and the adaptive-rate division (train, positive denominator only) use the divider.
// One request at a time: req_ready is high only when the sequencer is idle; a finished
// word waits in the output register. Synchronous active-high reset clears weights, window,
// count and handshakes, and loads output_rate with 0.7.
module mlp_online_backprop_trainer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_type,
   input  logic signed [31:0]            req_sample,
   input  logic [4:0]                    req_weight_index,
   input  logic signed [31:0]            req_weight_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [31:0]            rsp_prediction,
   output logic signed [31:0]            rsp_pred_error,
   output logic                          rsp_window_full,
   output logic signed [31:0]            rsp_read_value,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [30:0]                   csr_output_rate
);

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_NET    = 5'd1;
   localparam logic [4:0] ST_POLY1  = 5'd2;
   localparam logic [4:0] ST_POLY2  = 5'd3;
   localparam logic [4:0] ST_POLY3  = 5'd4;
   localparam logic [4:0] ST_SIGDIV = 5'd5;
   localparam logic [4:0] ST_Q      = 5'd6;
   localparam logic [4:0] ST_OUT    = 5'd7;
   localparam logic [4:0] ST_PRED   = 5'd8;
   localparam logic [4:0] ST_ERR    = 5'd9;
   localparam logic [4:0] ST_G1     = 5'd10;
   localparam logic [4:0] ST_G2     = 5'd11;
   localparam logic [4:0] ST_G3     = 5'd12;
   localparam logic [4:0] ST_A      = 5'd13;
   localparam logic [4:0] ST_QQ     = 5'd14;
   localparam logic [4:0] ST_B      = 5'd15;
   localparam logic [4:0] ST_OO     = 5'd16;
   localparam logic [4:0] ST_DEN    = 5'd17;
   localparam logic [4:0] ST_RDIV   = 5'd18;
   localparam logic [4:0] ST_RE     = 5'd19;
   localparam logic [4:0] ST_OW     = 5'd20;
   localparam logic [4:0] ST_OTH    = 5'd21;
   localparam logic [4:0] ST_S1     = 5'd22;
   localparam logic [4:0] ST_S2     = 5'd23;
   localparam logic [4:0] ST_HX     = 5'd24;
   localparam logic [4:0] ST_HW     = 5'd25;
   localparam logic [4:0] ST_HT     = 5'd26;
   localparam logic [4:0] ST_DONE   = 5'd27;

   localparam int DW = mobt_pkg::DW;

   // control
   logic [4:0]                 state_ff, state_in;
   logic                       ph_ff, ph_in;
   logic [mobt_pkg::KW-1:0]    k_ff, k_in;
   logic [mobt_pkg::IW-1:0]    i_ff, i_in;
   logic [mobt_pkg::PW-1:0]    ptr_ff, ptr_in;
   logic [CW_L-1:0]            cnt_ff, cnt_in;
   localparam int CW_L = mobt_pkg::CW;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [30:0]                rate_ff, rate_in;

   // network state
   logic signed [DW-1:0] win_ff [mobt_pkg::WINDOW];
   logic signed [DW-1:0] win_in [mobt_pkg::WINDOW];
   logic signed [DW-1:0] hw_ff  [mobt_pkg::NW];
   logic signed [DW-1:0] hw_in  [mobt_pkg::NW];
   logic signed [DW-1:0] ow_ff  [mobt_pkg::HIDDEN];
   logic signed [DW-1:0] ow_in  [mobt_pkg::HIDDEN];
   logic signed [DW-1:0] hth_ff [mobt_pkg::HIDDEN];
   logic signed [DW-1:0] hth_in [mobt_pkg::HIDDEN];
   logic signed [DW-1:0] oth_ff, oth_in;

   // request and working registers
   logic [2:0]                      req_ff, req_in;
   logic signed [DW-1:0]            sample_ff, sample_in;
   logic [4:0]                      widx_ff, widx_in;
   logic signed [DW-1:0]            wval_ff, wval_in;
   logic                            full_ff, full_in;
   logic signed [mobt_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic signed [mobt_pkg::ACC_W-1:0] oacc_ff, oacc_in;
   logic signed [DW-1:0] h_ff [mobt_pkg::HIDDEN];
   logic signed [DW-1:0] h_in [mobt_pkg::HIDDEN];
   logic signed [DW-1:0] q_ff [mobt_pkg::HIDDEN];
   logic signed [DW-1:0] q_in [mobt_pkg::HIDDEN];
   logic signed [DW-1:0] tmp_ff, tmp_in;
   logic signed [DW-1:0] t1_ff, t1_in;
   logic [mobt_pkg::FRAC_BITS:0] d_ff, d_in;
   logic signed [DW-1:0] pred_ff, pred_in;
   logic signed [DW-1:0] err_ff, err_in;
   logic signed [DW-1:0] a_ff, a_in;
   logic signed [DW-1:0] b_ff, b_in;
   logic signed [DW-1:0] rate2_ff, rate2_in;

   // result register
   logic signed [DW-1:0] rsp_pred_ff, rsp_pred_in;
   logic signed [DW-1:0] rsp_err_ff, rsp_err_in;
   logic                 rsp_full_ff, rsp_full_in;
   logic signed [DW-1:0] rsp_read_ff, rsp_read_in;

   // datapath
   logic signed [DW-1:0]  mul_a, mul_b;
   logic signed [63:0]    prod;
   logic signed [DW-1:0]  pq;
   logic signed [mobt_pkg::ACC_W-1:0] pt;
   mobt_pkg::div_cmd_type div_cmd;
   logic                  div_done;
   logic [mobt_pkg::NUM_W-1:0] div_quot;

   logic [mobt_pkg::PW-1:0] hw_addr;
   logic [mobt_pkg::KW-1:0] ow_addr, hth_addr;
   logic [4:0]              ow_off, hth_off;
   logic signed [DW-1:0]    hw_rd, ow_rd, hth_rd, win_rd, h_k, q_k, slot_val;
   logic                    net_neg, n_small;
   logic [mobt_pkg::ACC_W-1:0] net_mag;
   logic [mobt_pkg::ACC_W-mobt_pkg::FRAC_BITS-1:0] n_hi;
   logic [DW-1:0]           f30_op, poly_v, poly_sh, poly_d;
   logic                    last_k, last_i, ack, compute_req;

   mobt_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   mobt_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign req_ready       = (state_ff == ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prediction  = rsp_pred_ff;
   assign rsp_pred_error  = rsp_err_ff;
   assign rsp_window_full = rsp_full_ff;
   assign rsp_read_value  = rsp_read_ff;

   // one read port per weight array; the request index takes it over at the end
   assign ow_off   = widx_ff - 5'(mobt_pkg::NW);
   assign hth_off  = widx_ff - 5'(mobt_pkg::NW + mobt_pkg::HIDDEN);
   assign hw_addr  = (state_ff == ST_DONE) ? widx_ff[mobt_pkg::PW-1:0] : ptr_ff;
   assign ow_addr  = (state_ff == ST_DONE) ? ow_off[mobt_pkg::KW-1:0] : k_ff;
   assign hth_addr = (state_ff == ST_DONE) ? hth_off[mobt_pkg::KW-1:0] : k_ff;
   assign hw_rd    = hw_ff[hw_addr];
   assign ow_rd    = ow_ff[ow_addr];
   assign hth_rd   = hth_ff[hth_addr];
   assign win_rd   = win_ff[i_ff];
   assign h_k      = h_ff[k_ff];
   assign q_k      = q_ff[k_ff];

   assign pq = mobt_pkg::qmul(prod);
   assign pt = mobt_pkg::shr_frac(prod);

   assign last_k = (k_ff == mobt_pkg::KW'(mobt_pkg::HIDDEN - 1));
   assign last_i = (i_ff == mobt_pkg::IW'(mobt_pkg::WINDOW - 1));
   assign ack    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign compute_req = (req_ff == mobt_pkg::REQ_TRAIN) || (req_ff == mobt_pkg::REQ_PREDICT);

   // sigmoid pieces from the net held in acc
   assign net_neg = acc_ff[mobt_pkg::ACC_W-1];
   assign net_mag = net_neg ? -acc_ff : acc_ff;
   assign n_hi    = net_mag[mobt_pkg::ACC_W-1:mobt_pkg::FRAC_BITS];
   assign n_small = (n_hi < 31);
   assign f30_op  = DW'(net_mag[mobt_pkg::FRAC_BITS-1:0]) << (30 - mobt_pkg::FRAC_BITS);
   assign poly_v  = (DW'(1) << 30) - t1_ff + prod[61:30];
   assign poly_sh = poly_v >> n_hi[4:0];
   assign poly_d  = poly_sh >> (30 - mobt_pkg::FRAC_BITS);

   always_comb begin
      if (widx_ff < 5'(mobt_pkg::NW)) begin
         slot_val = hw_rd;
      end else if (widx_ff < 5'(mobt_pkg::NW + mobt_pkg::HIDDEN)) begin
         slot_val = ow_rd;
      end else if (widx_ff < 5'(mobt_pkg::NW + 2 * mobt_pkg::HIDDEN)) begin
         slot_val = hth_rd;
      end else if (widx_ff == 5'(mobt_pkg::NALL - 1)) begin
         slot_val = oth_ff;
      end else begin
         slot_val = '0;
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      unique case (state_ff)
         ST_NET:   begin mul_a = win_rd;  mul_b = hw_rd;          end
         ST_POLY1: begin mul_a = mobt_pkg::POLY_A; mul_b = f30_op; end
         ST_POLY2: begin mul_a = f30_op;  mul_b = f30_op;         end
         ST_POLY3: begin mul_a = mobt_pkg::POLY_B; mul_b = tmp_ff; end
         ST_Q:     begin mul_a = h_k;     mul_b = mobt_pkg::ONE - h_k; end
         ST_OUT:   begin mul_a = h_k;     mul_b = ow_rd;          end
         ST_G1:    begin mul_a = err_ff;  mul_b = ow_rd;          end
         ST_G2:    begin mul_a = tmp_ff;  mul_b = q_k;            end
         ST_G3:    begin mul_a = tmp_ff;  mul_b = tmp_ff;         end
         ST_A:     begin mul_a = tmp_ff;  mul_b = q_k;            end
         ST_QQ:    begin mul_a = q_k;     mul_b = q_k;            end
         ST_B:     begin mul_a = tmp_ff;  mul_b = t1_ff;          end
         ST_OO:    begin mul_a = pred_ff; mul_b = pred_ff;        end
         ST_DEN:   begin mul_a = b_ff;    mul_b = tmp_ff;         end
         ST_RE:    begin mul_a = {1'b0, rate_ff}; mul_b = err_ff; end
         ST_OW:    begin mul_a = tmp_ff;  mul_b = h_k;            end
         ST_S1:    begin mul_a = err_ff;  mul_b = ow_rd;          end
         ST_S2:    begin mul_a = tmp_ff;  mul_b = q_k;            end
         ST_HX:    begin mul_a = win_rd;  mul_b = t1_ff;          end
         ST_HW:    begin mul_a = rate2_ff; mul_b = tmp_ff;        end
         ST_HT:    begin mul_a = rate2_ff; mul_b = t1_ff;         end
         default:  begin mul_a = '0;      mul_b = '0;             end
      endcase
   end

   always_comb begin
      div_cmd.start = (state_ff == ST_SIGDIV || state_ff == ST_RDIV) && !ph_ff;
      if (state_ff == ST_RDIV) begin
         div_cmd.num = mobt_pkg::NUM_W'(a_ff[DW-2:0]) << (mobt_pkg::FRAC_BITS + 2);
         div_cmd.den = tmp_ff;
      end else begin
         div_cmd.num = net_neg ? (mobt_pkg::NUM_W'(d_ff) << mobt_pkg::FRAC_BITS)
                               : (mobt_pkg::NUM_W'(1) << (2 * mobt_pkg::FRAC_BITS));
         div_cmd.den = DW'(mobt_pkg::ONE) + DW'(d_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      ph_in    = ph_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      ptr_in   = ptr_ff;
      cnt_in   = cnt_ff;
      rate_in  = rate_ff;
      win_in   = win_ff;
      hw_in    = hw_ff;
      ow_in    = ow_ff;
      hth_in   = hth_ff;
      oth_in   = oth_ff;
      req_in   = req_ff;
      sample_in = sample_ff;
      widx_in  = widx_ff;
      wval_in  = wval_ff;
      full_in  = full_ff;
      acc_in   = acc_ff;
      oacc_in  = oacc_ff;
      h_in     = h_ff;
      q_in     = q_ff;
      tmp_in   = tmp_ff;
      t1_in    = t1_ff;
      d_in     = d_ff;
      pred_in  = pred_ff;
      err_in   = err_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      rate2_in = rate2_ff;
      rsp_pred_in = rsp_pred_ff;
      rsp_err_in  = rsp_err_ff;
      rsp_full_in = rsp_full_ff;
      rsp_read_in = rsp_read_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_valid) begin
         rate_in = csr_output_rate;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_type;
               sample_in = req_sample;
               widx_in   = req_weight_index;
               wval_in   = req_weight_value;
               full_in   = (cnt_ff == CW_L'(mobt_pkg::WINDOW));
               k_in      = '0;
               i_in      = '0;
               ptr_in    = '0;
               ph_in     = 1'b0;
               acc_in    = '0;
               oacc_in   = '0;
               a_in      = '0;
               b_in      = '0;
               pred_in   = '0;
               err_in    = '0;
               if ((req_type == mobt_pkg::REQ_TRAIN || req_type == mobt_pkg::REQ_PREDICT)
                   && cnt_ff == CW_L'(mobt_pkg::WINDOW)) begin
                  state_in = ST_NET;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SIGDIV, ST_RDIV: begin
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else if (div_done) begin
               ph_in = 1'b0;
               if (state_ff == ST_SIGDIV) begin
                  h_in[k_ff] = div_quot[DW-1:0];
                  state_in   = ST_Q;
               end else begin
                  rate2_in = (div_quot > mobt_pkg::NUM_W'(mobt_pkg::S32_MAX))
                             ? mobt_pkg::S32_MAX : div_quot[DW-1:0];
                  state_in = ST_RE;
               end
            end
         end
         ST_PRED: begin
            pred_in  = mobt_pkg::sat32(oacc_ff - mobt_pkg::sext(oth_ff));
            state_in = ST_ERR;
         end
         ST_ERR: begin
            err_in   = mobt_pkg::sat32(mobt_pkg::sext(pred_ff) - mobt_pkg::sext(sample_ff));
            k_in     = '0;
            state_in = (req_ff == mobt_pkg::REQ_TRAIN) ? ST_G1 : ST_DONE;
         end
         ST_OTH: begin
            oth_in   = mobt_pkg::sat32(mobt_pkg::sext(oth_ff) + mobt_pkg::sext(tmp_ff));
            k_in     = '0;
            i_in     = '0;
            ptr_in   = '0;
            state_in = ST_S1;
         end
         ST_DONE: begin
            if (ack) begin
               rsp_pred_in  = pred_ff;
               rsp_err_in   = err_ff;
               rsp_read_in  = (req_ff == mobt_pkg::REQ_READ) ? slot_val : '0;
               rsp_full_in  = (cnt_ff == CW_L'(mobt_pkg::WINDOW));
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (compute_req) begin
                  rsp_full_in = full_ff;
                  for (int j = 0; j < mobt_pkg::WINDOW - 1; j++) begin
                     win_in[j] = win_ff[j + 1];
                  end
                  win_in[mobt_pkg::WINDOW - 1] = sample_ff;
                  if (cnt_ff != CW_L'(mobt_pkg::WINDOW)) begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end else if (req_ff == mobt_pkg::REQ_WRITE) begin
                  if (widx_ff < 5'(mobt_pkg::NW)) begin
                     hw_in[hw_addr] = wval_ff;
                  end else if (widx_ff < 5'(mobt_pkg::NW + mobt_pkg::HIDDEN)) begin
                     ow_in[ow_addr] = wval_ff;
                  end else if (widx_ff < 5'(mobt_pkg::NW + 2 * mobt_pkg::HIDDEN)) begin
                     hth_in[hth_addr] = wval_ff;
                  end else if (widx_ff == 5'(mobt_pkg::NALL - 1)) begin
                     oth_in = wval_ff;
                  end
               end else if (req_ff == mobt_pkg::REQ_CLEAR) begin
                  for (int j = 0; j < mobt_pkg::WINDOW; j++) begin
                     win_in[j] = '0;
                  end
                  cnt_in      = '0;
                  rsp_full_in = 1'b0;
               end
            end
         end
         default: begin
            // multiply states: issue in phase 0, write back in phase 1
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else begin
               ph_in = 1'b0;
               priority case (state_ff)
                  ST_NET: begin
                     ptr_in = ptr_ff + 1'b1;
                     if (last_i) begin
                        acc_in   = acc_ff + pt - mobt_pkg::sext(hth_rd);
                        i_in     = '0;
                        state_in = ST_POLY1;
                     end else begin
                        acc_in = acc_ff + pt;
                        i_in   = i_ff + 1'b1;
                     end
                  end
                  ST_POLY1: begin
                     t1_in    = prod[61:30];
                     state_in = ST_POLY2;
                  end
                  ST_POLY2: begin
                     tmp_in   = prod[61:30];
                     state_in = ST_POLY3;
                  end
                  ST_POLY3: begin
                     d_in     = n_small ? poly_d[mobt_pkg::FRAC_BITS:0] : '0;
                     state_in = ST_SIGDIV;
                  end
                  ST_Q: begin
                     q_in[k_ff] = pq;
                     state_in   = ST_OUT;
                  end
                  ST_OUT: begin
                     oacc_in = oacc_ff + pt;
                     if (last_k) begin
                        state_in = ST_PRED;
                     end else begin
                        k_in     = k_ff + 1'b1;
                        acc_in   = '0;
                        state_in = ST_NET;
                     end
                  end
                  ST_G1: begin tmp_in = pq; state_in = ST_G2; end
                  ST_G2: begin tmp_in = pq; state_in = ST_G3; end
                  ST_G3: begin tmp_in = pq; state_in = ST_A;  end
                  ST_A: begin
                     a_in     = mobt_pkg::sat32(mobt_pkg::sext(a_ff) + mobt_pkg::sext(pq));
                     state_in = ST_QQ;
                  end
                  ST_QQ: begin t1_in = pq; state_in = ST_B; end
                  ST_B: begin
                     b_in = mobt_pkg::sat32(mobt_pkg::sext(b_ff) + mobt_pkg::sext(pq));
                     if (last_k) begin
                        k_in     = '0;
                        state_in = ST_OO;
                     end else begin
                        k_in     = k_ff + 1'b1;
                        state_in = ST_G1;
                     end
                  end
                  ST_OO: begin
                     tmp_in   = mobt_pkg::sat32(mobt_pkg::sext(mobt_pkg::ONE)
                                                + mobt_pkg::sext(pq));
                     state_in = ST_DEN;
                  end
                  ST_DEN: begin
                     tmp_in = pq;
                     if (pq > 32'sd0) begin
                        state_in = ST_RDIV;
                     end else begin
                        rate2_in = '0;
                        state_in = ST_RE;
                     end
                  end
                  ST_RE: begin
                     tmp_in   = pq;
                     k_in     = '0;
                     state_in = ST_OW;
                  end
                  ST_OW: begin
                     ow_in[k_ff] = mobt_pkg::sat32(mobt_pkg::sext(ow_rd) - mobt_pkg::sext(pq));
                     if (last_k) begin
                        state_in = ST_OTH;
                     end else begin
                        k_in = k_ff + 1'b1;
                     end
                  end
                  ST_S1: begin tmp_in = pq; state_in = ST_S2; end
                  ST_S2: begin t1_in  = pq; state_in = ST_HX; end
                  ST_HX: begin tmp_in = pq; state_in = ST_HW; end
                  ST_HW: begin
                     hw_in[hw_addr] = mobt_pkg::sat32(mobt_pkg::sext(hw_rd)
                                                      - mobt_pkg::sext(pq));
                     ptr_in = ptr_ff + 1'b1;
                     if (last_i) begin
                        i_in     = '0;
                        state_in = ST_HT;
                     end else begin
                        i_in     = i_ff + 1'b1;
                        state_in = ST_HX;
                     end
                  end
                  ST_HT: begin
                     hth_in[k_ff] = mobt_pkg::sat32(mobt_pkg::sext(hth_rd)
                                                    + mobt_pkg::sext(pq));
                     if (last_k) begin
                        state_in = ST_DONE;
                     end else begin
                        k_in     = k_ff + 1'b1;
                        state_in = ST_S1;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ph_ff        <= 1'b0;
         k_ff         <= '0;
         i_ff         <= '0;
         ptr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rate_ff      <= mobt_pkg::RATE_RESET;
         oth_ff       <= '0;
         for (int j = 0; j < mobt_pkg::WINDOW; j++) begin
            win_ff[j] <= '0;
         end
         for (int j = 0; j < mobt_pkg::NW; j++) begin
            hw_ff[j] <= '0;
         end
         for (int j = 0; j < mobt_pkg::HIDDEN; j++) begin
            ow_ff[j]  <= '0;
            hth_ff[j] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         k_ff         <= k_in;
         i_ff         <= i_in;
         ptr_ff       <= ptr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rate_ff      <= rate_in;
         oth_ff       <= oth_in;
         win_ff       <= win_in;
         hw_ff        <= hw_in;
         ow_ff        <= ow_in;
         hth_ff       <= hth_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      sample_ff   <= sample_in;
      widx_ff     <= widx_in;
      wval_ff     <= wval_in;
      full_ff     <= full_in;
      acc_ff      <= acc_in;
      oacc_ff     <= oacc_in;
      h_ff        <= h_in;
      q_ff        <= q_in;
      tmp_ff      <= tmp_in;
      t1_ff       <= t1_in;
      d_ff        <= d_in;
      pred_ff     <= pred_in;
      err_ff      <= err_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      rate2_ff    <= rate2_in;
      rsp_pred_ff <= rsp_pred_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_full_ff <= rsp_full_in;
      rsp_read_ff <= rsp_read_in;
   end

endmodule

// File: rtl/core/mobt_chk.sv
`timescale 1ns / 1ps
// Port-level checker for mlp_online_backprop_trainer, attached with bind.
// Depends only on the top level's ports.
module mobt_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_prediction,
   input logic signed [31:0] rsp_pred_error,
   input logic               rsp_window_full,
   input logic signed [31:0] rsp_read_value
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_prediction)
                                  && $stable(rsp_pred_error) && $stable(rsp_read_value))
      else $error("result word changed while stalled");

   a_read_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_value != 0 |-> rsp_prediction == 0 && rsp_pred_error == 0)
      else $error("read word carries a prediction");

   a_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_window_full |-> rsp_prediction == 0 && rsp_pred_error == 0)
      else $error("prediction without a full window");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accepting a word");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> req_ready && !rsp_valid)
      else $error("not idle after reset");

endmodule

bind mlp_online_backprop_trainer mobt_chk u_mobt_chk (.*);

// File: dv/tb_mlp_online_backprop_trainer.sv
`timescale 1ns / 1ps
// Testbench for mlp_online_backprop_trainer: directed table, then random phases per rate.
// Every response word is checked against its typed table answer or an in-bench fixed-point network model.
module tb_mlp_online_backprop_trainer;
   import mobt_pkg::*;

   localparam logic [2:0] REQ_SPARE_LO = 3'd5;
   localparam logic [2:0] REQ_SPARE_HI = 3'd7;
   localparam longint UNIT    = 64'sd1 << FRAC_BITS;
   localparam longint S_MAX   = 64'sd2147483647;
   localparam longint S_MIN   = -64'sd2147483648;
   localparam bit [63:0] EXP_C1 = 64'd721095906;
   localparam bit [63:0] EXP_C2 = 64'd184224994;
   localparam int STALL_LIMIT = 20000;
   localparam int LONG_HOLD   = 2000;
   localparam int PHASE_WORDS = 270;

   typedef struct {
      logic [2:0]         kind;
      logic signed [31:0] sample;
      logic [4:0]         idx;
      logic signed [31:0] value;
   } request_t;

   typedef struct {
      logic signed [31:0] pred;
      logic signed [31:0] err;
      logic               full;
      logic signed [31:0] rd;
   } answer_t;

   typedef struct {
      request_t rq;
      bit       typed;
      answer_t  ans;
   } row_t;

   logic clock = 0;
   logic reset;
   logic req_valid, req_ready;
   logic [2:0] req_type;
   logic signed [31:0] req_sample, req_weight_value;
   logic [4:0] req_weight_index;
   logic rsp_valid, rsp_ready;
   logic signed [31:0] rsp_prediction, rsp_pred_error, rsp_read_value;
   logic rsp_window_full;
   logic csr_valid, csr_ready;
   logic [30:0] csr_output_rate;

   mlp_online_backprop_trainer u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_sample(req_sample), .req_weight_index(req_weight_index),
      .req_weight_value(req_weight_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_prediction(rsp_prediction),
      .rsp_pred_error(rsp_pred_error), .rsp_window_full(rsp_window_full),
      .rsp_read_value(rsp_read_value),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_output_rate(csr_output_rate)
   );

   always #5 clock = ~clock;

   // network model state
   longint win[WINDOW];
   longint hw[NW];
   longint ow[HIDDEN];
   longint ht[HIDDEN];
   longint ot;
   int     fill;
   longint rate;

   answer_t expected_words[$];
   row_t    table_rows[$];
   int      err_count = 0;
   int      send_idle = 0;
   int      recv_stall = 0;
   int      hold_cycles = 0;
   int      quiet = 0;

   function automatic longint clamp32(longint v);
      if (v > S_MAX) return S_MAX;
      if (v < S_MIN) return S_MIN;
      return v;
   endfunction

   function automatic longint floor_frac(longint p);
      return p >>> FRAC_BITS;
   endfunction

   function automatic longint fxmul(longint a, longint b);
      return clamp32(floor_frac(a * b));
   endfunction

   function automatic longint sigmoid2(longint net);
      bit neg;
      bit [63:0] mag, n, f30, t1, f2, t2, p, d, one_u;
      neg = net < 0;
      mag = neg ? -net : net;
      one_u = UNIT;
      n = mag >> FRAC_BITS;
      f30 = (mag & (one_u - 1)) << (30 - FRAC_BITS);
      d = 0;
      if (n < 31) begin
         t1 = (EXP_C1 * f30) >> 30;
         f2 = (f30 * f30) >> 30;
         t2 = (EXP_C2 * f2) >> 30;
         p = (64'd1 << 30) - t1 + t2;
         d = (p >> n) >> (30 - FRAC_BITS);
      end
      if (!neg) return longint'((one_u << FRAC_BITS) / (one_u + d));
      return longint'((d << FRAC_BITS) / (one_u + d));
   endfunction

   function automatic void adapt(longint e, longint o, longint h[HIDDEN], longint q[HIDDEN]);
      longint a, b, rate2, den, num, g, g2, s;
      a = 0; b = 0; rate2 = 0;
      for (int i = 0; i < HIDDEN; i++) begin
         g  = fxmul(fxmul(e, ow[i]), q[i]);
         g2 = fxmul(g, g);
         a  = clamp32(a + fxmul(g2, q[i]));
         b  = clamp32(b + fxmul(g2, fxmul(q[i], q[i])));
      end
      den = fxmul(b, clamp32(UNIT + fxmul(o, o)));
      if (den > 0) begin
         num = (4 * a) * UNIT;
         rate2 = clamp32(num / den);
      end
      for (int i = 0; i < HIDDEN; i++)
         ow[i] = clamp32(ow[i] - fxmul(fxmul(rate, e), h[i]));
      ot = clamp32(ot + fxmul(rate, e));
      for (int k = 0; k < HIDDEN; k++) begin
         s = fxmul(fxmul(e, ow[k]), q[k]);
         for (int i = 0; i < WINDOW; i++)
            hw[k*WINDOW+i] = clamp32(hw[k*WINDOW+i] - fxmul(rate2, fxmul(win[i], s)));
         ht[k] = clamp32(ht[k] + fxmul(rate2, s));
      end
   endfunction

   function automatic answer_t network_step(request_t r);
      answer_t a;
      longint h[HIDDEN], q[HIDDEN], acc, net, pred, err, rd;
      int x;
      bit full;
      pred = 0; err = 0; rd = 0;
      full = fill >= WINDOW;
      x = r.idx;
      if (r.kind == REQ_TRAIN || r.kind == REQ_PREDICT) begin
         if (full) begin
            acc = 0;
            for (int k = 0; k < HIDDEN; k++) begin
               net = 0;
               for (int i = 0; i < WINDOW; i++) net += floor_frac(win[i] * hw[k*WINDOW+i]);
               h[k] = sigmoid2(net - ht[k]);
               q[k] = fxmul(h[k], UNIT - h[k]);
               acc += floor_frac(h[k] * ow[k]);
            end
            pred = clamp32(acc - ot);
            err  = clamp32(pred - longint'(r.sample));
            if (r.kind == REQ_TRAIN) adapt(err, pred, h, q);
         end
         for (int i = 0; i + 1 < WINDOW; i++) win[i] = win[i+1];
         win[WINDOW-1] = r.sample;
         if (fill < WINDOW) fill++;
      end else begin
         if (r.kind == REQ_WRITE) begin
            if (x < NW) hw[x] = r.value;
            else if (x < NW + HIDDEN) ow[x-NW] = r.value;
            else if (x < NW + 2*HIDDEN) ht[x-NW-HIDDEN] = r.value;
            else if (x == NALL - 1) ot = r.value;
         end else if (r.kind == REQ_READ) begin
            if (x < NW) rd = hw[x];
            else if (x < NW + HIDDEN) rd = ow[x-NW];
            else if (x < NW + 2*HIDDEN) rd = ht[x-NW-HIDDEN];
            else if (x == NALL - 1) rd = ot;
         end else if (r.kind == REQ_CLEAR) begin
            for (int i = 0; i < WINDOW; i++) win[i] = 0;
            fill = 0;
         end
         full = fill >= WINDOW;
      end
      a.pred = pred[31:0];
      a.err  = err[31:0];
      a.full = full;
      a.rd   = rd[31:0];
      return a;
   endfunction

   function automatic logic signed [31:0] pick_sample();
      if ($urandom_range(0, 99) < 85) return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      return $urandom;
   endfunction

   function automatic request_t random_request();
      request_t r;
      int c;
      c = $urandom_range(0, 99);
      if (c < 55) r.kind = REQ_TRAIN;
      else if (c < 75) r.kind = REQ_PREDICT;
      else if (c < 85) r.kind = REQ_WRITE;
      else if (c < 93) r.kind = REQ_READ;
      else if (c < 96) r.kind = REQ_CLEAR;
      else r.kind = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
      r.sample = pick_sample();
      r.idx = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(NALL, 31))
                                          : 5'($urandom_range(0, NALL - 1));
      r.value = ($urandom_range(0, 9) < 7) ? $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000
                                           : $signed($urandom);
      return r;
   endfunction

   function automatic void add_row(logic [2:0] k, logic signed [31:0] smp, logic [4:0] ix,
                                   logic signed [31:0] val, bit typed,
                                   logic signed [31:0] rd = 0, logic full = 0);
      row_t w;
      w.rq.kind = k; w.rq.sample = smp; w.rq.idx = ix; w.rq.value = val;
      w.typed = typed;
      w.ans.pred = 0; w.ans.err = 0; w.ans.full = full; w.ans.rd = rd;
      table_rows.push_back(w);
   endfunction

   task automatic report(string what, logic signed [31:0] got, logic signed [31:0] want);
      $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   task automatic offer(request_t r, bit typed, answer_t typed_ans);
      answer_t a;
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_type <= r.kind;
      req_sample <= r.sample;
      req_weight_index <= r.idx;
      req_weight_value <= r.value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      a = network_step(r);
      expected_words.push_back(typed ? typed_ans : a);
   endtask

   task automatic drain_and_configure(logic [30:0] new_rate);
      req_valid <= 0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_valid <= 1;
      csr_output_rate <= new_rate;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      rate = new_rate;
      @(posedge clock);
   endtask

   // response side: random stall plus one long hold-off
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall);
      end
   end

   always @(posedge clock) begin
      answer_t w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            report("unexpected word", rsp_prediction, 0);
         end else begin
            w = expected_words.pop_front();
            if (rsp_prediction !== w.pred) report("prediction", rsp_prediction, w.pred);
            if (rsp_pred_error !== w.err) report("pred_error", rsp_pred_error, w.err);
            if (rsp_window_full !== w.full) report("window_full", rsp_window_full, w.full);
            if (rsp_read_value !== w.rd) report("read_value", rsp_read_value, w.rd);
         end
      end
   end

   // watchdog on accepted words of any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      answer_t none;
      logic [30:0] rates[6];
      reset <= 1;
      req_valid <= 0;
      req_type <= REQ_PREDICT;
      req_sample <= 0;
      req_weight_index <= 0;
      req_weight_value <= 0;
      csr_valid <= 0;
      csr_output_rate <= 0;
      rsp_ready <= 0;
      for (int i = 0; i < WINDOW; i++) win[i] = 0;
      for (int i = 0; i < NW; i++) hw[i] = 0;
      for (int i = 0; i < HIDDEN; i++) begin ow[i] = 0; ht[i] = 0; end
      ot = 0; fill = 0; rate = RATE_RESET;
      none = '{default: 0};

      // reset values, extremes, ignored indexes, partial window, spare codes, clear
      add_row(REQ_READ, 0, 0, 0, 1);
      add_row(REQ_READ, 0, 16, 0, 1);
      add_row(REQ_READ, 0, 31, 0, 1);
      add_row(REQ_WRITE, 0, 16, 32'sh7FFF_FFFF, 1);
      add_row(REQ_READ, 0, 16, 0, 1, 32'sh7FFF_FFFF);
      add_row(REQ_WRITE, 0, 31, 32'sh1234_5678, 1);
      add_row(REQ_READ, 0, 17, 0, 1);
      add_row(REQ_WRITE, 0, 0, 32'sh8000_0000, 1);
      add_row(REQ_READ, 0, 0, 0, 1, 32'sh8000_0000);
      add_row(REQ_WRITE, 0, 12, 32'sh0100_0000, 1);
      add_row(REQ_WRITE, 0, 14, 32'shFF00_0000, 1);
      add_row(REQ_PREDICT, 32'sh7FFF_FFFF, 0, 0, 1);
      add_row(REQ_TRAIN, 32'sh8000_0000, 0, 0, 1);
      add_row(REQ_TRAIN, 32'sh0100_0000, 0, 0, 1);
      add_row(REQ_TRAIN, 32'shFF80_0000, 0, 0, 1);
      add_row(REQ_TRAIN, 32'sh0000_0001, 0, 0, 1);
      add_row(REQ_TRAIN, 32'sh0200_0000, 0, 0, 1);
      add_row(REQ_TRAIN, 32'sh0000_0000, 0, 0, 0);
      add_row(REQ_PREDICT, 32'sh7FFF_FFFF, 0, 0, 0);
      add_row(REQ_TRAIN, 32'sh8000_0000, 0, 0, 0);
      add_row(REQ_SPARE_LO, 0, 0, 0, 1, 0, 1);
      add_row(REQ_SPARE_HI, 0, 0, 0, 1, 0, 1);
      add_row(REQ_CLEAR, 0, 0, 0, 1);
      add_row(REQ_TRAIN, 32'sh0100_0000, 0, 0, 1);
      add_row(REQ_READ, 0, 12, 0, 0);

      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (table_rows[i]) offer(table_rows[i].rq, table_rows[i].typed, table_rows[i].ans);

      rates[0] = 31'd0;
      rates[1] = 31'h7FFF_FFFF;
      rates[2] = RATE_RESET;
      rates[3] = 31'd1;
      rates[4] = 31'($urandom_range(0, 32'h0400_0000));
      rates[5] = 31'($urandom);
      for (int ph = 0; ph < 6; ph++) begin
         drain_and_configure(rates[ph]);
         case (ph % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 72; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 72; end
            default: begin send_idle = 13; recv_stall = 13; end
         endcase
         // back up the output so the block stalls its input
         if (ph == 4) hold_cycles = LONG_HOLD;
         for (int n = 0; n < PHASE_WORDS; n++) offer(random_request(), 0, none);
      end
      req_valid <= 0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/mobt_pkg.sv
rtl/core/mobt_mul.sv
rtl/core/mobt_div.sv
rtl/core/mlp_online_backprop_trainer.sv
rtl/core/mobt_chk.sv
dv/tb_mlp_online_backprop_trainer.sv
